// ----- design/aar_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package aar_pkg;

  // Internal fixed-point format of the trig and matrix datapath (Q2.30 in 34 bits).
  localparam int WF = 30;
  localparam logic signed [33:0] ONE_WF  = 34'sd1073741824;
  localparam logic signed [33:0] KINV_WF = 34'sd652032874;

  // round(pi / 180 * 2^32)
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

  typedef logic signed [33:0] cw_t;
  typedef logic [2:0][31:0]   vec3_t;

  typedef struct packed {
    logic [8:0][31:0] m;
    logic             zero;
  } res_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/aar_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one axis-angle vector per request.
interface aar_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;

  modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface

// Result channel: one rotation matrix per request.
interface aar_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic               zero_axis;

  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  output zero_axis, input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10,
                  input m11, input m12, input m20, input m21, input m22,
                  input zero_axis, output ready);
endinterface

`default_nettype wire

// ----- design/axis_angle_rotation_matrix.sv -----
// Axis-angle to rotation matrix.
// A request on in_ch carries a vector (rot_x, rot_y, rot_z) in signed Q16.16 degrees
// (IN_FRAC_BITS). Its direction is the rotation axis and its length the angle.
// out_ch returns the nine entries m00..m22 of the inverse rotation, row-vector
// layout, in signed Q1.30 (OUT_FRAC_BITS), saturated to plus/minus one. An all-zero
// vector returns the identity with zero_axis set.
// Both channels use valid/ready; a request moves on a clock edge with both high.
// Throughput: one request per cycle while out_ch.ready stays high.
// QB = 33 - clog2(360 * 2^IN_FRAC_BITS) is the number of angle reduction stages
// (8 at the defaults). The length square root (32 stages) and the axis division
// make up most of the pipeline depth, one result bit per stage.
// When out_ch.ready is low the result waits in the output register and one more
// result is caught in a skid register; only then does in_ch.ready drop and the
// whole pipeline hold. Nothing is lost or repeated across a stall.
// Reset (rst_n low, synchronous) empties the pipeline and both output registers.
`timescale 1ns / 1ps
`default_nettype none

module axis_angle_rotation_matrix
  import aar_pkg::*;
#(
  parameter int IN_FRAC_BITS    = 16,
  parameter int OUT_FRAC_BITS   = 30,
  parameter int TRIG_ITERATIONS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  aar_in_if.sink    in_ch,
  aar_out_if.source out_ch
);

  localparam int          SIDE_W  = $bits(vec3_t) + 1;
  localparam logic [31:0] ONE_OUT = 32'(64'd1 << OUT_FRAC_BITS);

  logic              en;
  vec3_t             in_r;

  logic              sq_v;
  logic [31:0]       sq_len;
  vec3_t             sq_r;

  logic              nm_v;
  logic [31:0]       nm_len;
  vec3_t             nm_n;
  logic              nm_zero;

  logic              sc_v;
  cw_t               sc_s;
  cw_t               sc_c;
  cw_t               sc_t;
  logic [SIDE_W-1:0] sc_side;

  logic              mx_v;
  res_t              mx_res;

  logic              out_v_r;
  res_t              out_r;
  logic              skid_v_r;
  res_t              skid_r;

  // The pipeline moves whenever the skid register is free.
  assign en          = !skid_v_r;
  assign in_ch.ready = en;
  assign in_r        = {in_ch.rot_z, in_ch.rot_y, in_ch.rot_x};

  aar_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_ch.valid),
    .in_r    (in_r),
    .out_v   (sq_v),
    .out_len (sq_len),
    .out_r   (sq_r)
  );

  aar_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (sq_v),
    .in_len   (sq_len),
    .in_r     (sq_r),
    .out_v    (nm_v),
    .out_len  (nm_len),
    .out_n    (nm_n),
    .out_zero (nm_zero)
  );

  aar_sincos #(
    .IN_FRAC_BITS    (IN_FRAC_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS),
    .SIDE_W          (SIDE_W)
  ) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (nm_v),
    .in_len   (nm_len),
    .in_side  ({nm_n, nm_zero}),
    .out_v    (sc_v),
    .out_s    (sc_s),
    .out_c    (sc_c),
    .out_t    (sc_t),
    .out_side (sc_side)
  );

  aar_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (sc_v),
    .in_s    (sc_s),
    .in_c    (sc_c),
    .in_t    (sc_t),
    .in_n    (sc_side[SIDE_W-1:1]),
    .in_zero (sc_side[0]),
    .out_v   (mx_v),
    .out_res (mx_res)
  );

  // Output register with a one-entry skid behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= en && mx_v;
      end
    end else if (en && mx_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : mx_res;
    end else if (en && mx_v) begin
      skid_r <= mx_res;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.m00       = out_r.m[0];
  assign out_ch.m01       = out_r.m[1];
  assign out_ch.m02       = out_r.m[2];
  assign out_ch.m10       = out_r.m[3];
  assign out_ch.m11       = out_r.m[4];
  assign out_ch.m12       = out_r.m[5];
  assign out_ch.m20       = out_r.m[6];
  assign out_ch.m21       = out_r.m[7];
  assign out_ch.m22       = out_r.m[8];
  assign out_ch.zero_axis = out_r.zero;

  // The skid register only ever fills behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output register is empty");

  // A result leaving the pipeline during an output stall must land in the skid.
  a_stall_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (en && mx_v && out_v_r && !out_ch.ready) |=> skid_v_r)
    else $error("result from the pipeline dropped during an output stall");

  // A zero-length vector always shows the identity.
  a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_ch.zero_axis) |->
      (out_ch.m00 == ONE_OUT && out_ch.m11 == ONE_OUT && out_ch.m22 == ONE_OUT &&
       out_ch.m01 == 32'd0 && out_ch.m10 == 32'd0))
    else $error("zero-axis result is not the identity");

endmodule

`default_nettype wire

// ----- design/aar_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aar_isqrt
  import aar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  vec3_t       in_r,
  output logic        out_v,
  output logic [31:0] out_len,
  output vec3_t       out_r
);

  localparam int STEPS = 32;

  logic [2:0][31:0] mag;
  logic [2:0][63:0] sq_r;
  logic             sq_v_r;
  vec3_t            sq_side_r;

  logic [63:0] rad_r  [STEPS+1];
  logic [35:0] rem_r  [STEPS+1];
  logic [31:0] root_r [STEPS+1];
  logic        v_r    [STEPS+1];
  vec3_t       side_r [STEPS+1];

  // Magnitudes of the components; the most negative value maps to 2^31.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = in_r[k][31] ? (~in_r[k] + 32'd1) : in_r[k];
    end
  end

  // Squares, one multiplier per component.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= 64'(mag[k]) * 64'(mag[k]);
      end
      sq_side_r <= in_r;
    end
  end

  // Sum of squares seeds the root recurrence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= sq_r[0] + sq_r[1] + sq_r[2];
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= sq_side_r;
    end
  end

  // One root bit per stage, restoring form.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] rem_nxt;
    logic [31:0] root_nxt;
    logic        ge;

    always_comb begin
      rem_sh   = {rem_r[k][33:0], rad_r[k][63:62]};
      trial    = {2'b00, root_r[k], 2'b01};
      ge       = rem_sh >= trial;
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[k][30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= {rad_r[k][61:0], 2'b00};
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_v   = v_r[STEPS];
  assign out_len = root_r[STEPS];
  assign out_r   = side_r[STEPS];

endmodule

`default_nettype wire

// ----- design/aar_norm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aar_norm
  import aar_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  logic [31:0] in_len,
  input  vec3_t       in_r,
  output logic        out_v,
  output logic [31:0] out_len,
  output vec3_t       out_n,
  output logic        out_zero
);

  // Quotient is at most 2^WF, so WF+1 bits and as many steps.
  localparam int QW = WF + 1;
  localparam int NW = 32 + WF;

  logic [2:0][NW-1:0] num;

  logic [2:0][31:0]   rem_r [QW+1];
  logic [2:0][QW-1:0] nlo_r [QW+1];
  logic [2:0][QW-1:0] q_r   [QW+1];
  logic [2:0]         sg_r  [QW+1];
  logic [31:0]        len_r [QW+1];
  logic               v_r   [QW+1];

  logic               o_v_r;
  logic [31:0]        o_len_r;
  vec3_t              o_n_r;
  logic               o_zero_r;

  // Rounded numerator: |r| * 2^WF + len / 2.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      logic [31:0] mag;
      mag    = in_r[l][31] ? (~in_r[l] + 32'd1) : in_r[l];
      num[l] = {mag, {WF{1'b0}}} + NW'(in_len[31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= 32'(num[l][NW-1:QW]);
        nlo_r[0][l] <= num[l][QW-1:0];
        q_r[0][l]   <= '0;
        sg_r[0][l]  <= in_r[l][31];
      end
      len_r[0] <= in_len;
    end
  end

  // One quotient bit per stage for each of the three lanes.
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [2:0][31:0]   rem_nxt;
    logic [2:0][QW-1:0] q_nxt;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        logic [32:0] rsh;
        logic        ge;
        rsh        = {rem_r[k][l], nlo_r[k][l][QW-1]};
        ge         = rsh >= {1'b0, len_r[k]};
        rem_nxt[l] = ge ? 32'(rsh - {1'b0, len_r[k]}) : rsh[31:0];
        q_nxt[l]   = {q_r[k][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          nlo_r[k+1][l] <= {nlo_r[k][l][QW-2:0], 1'b0};
        end
        rem_r[k+1] <= rem_nxt;
        q_r[k+1]   <= q_nxt;
        sg_r[k+1]  <= sg_r[k];
        len_r[k+1] <= len_r[k];
      end
    end
  end

  // Clamp to one and restore the component sign.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic [31:0] qc;
        qc = (32'(q_r[QW][l]) > (32'd1 << WF)) ? (32'd1 << WF) : 32'(q_r[QW][l]);
        o_n_r[l] <= sg_r[QW][l] ? (~qc + 32'd1) : qc;
      end
      o_len_r  <= len_r[QW];
      o_zero_r <= (len_r[QW] == 32'd0);
    end
  end

  assign out_v    = o_v_r;
  assign out_len  = o_len_r;
  assign out_n    = o_n_r;
  assign out_zero = o_zero_r;

endmodule

`default_nettype wire

// ----- design/aar_sincos.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aar_sincos
  import aar_pkg::*;
#(
  parameter int IN_FRAC_BITS    = 16,
  parameter int TRIG_ITERATIONS = 24,
  parameter int SIDE_W          = 97
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [31:0]       in_len,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_v,
  output cw_t               out_s,
  output cw_t               out_c,
  output cw_t               out_t,
  output logic [SIDE_W-1:0] out_side
);

  localparam logic [63:0] MOD_C = 64'd360 << IN_FRAC_BITS;
  localparam logic [63:0] Q90   = 64'd90 << IN_FRAC_BITS;
  localparam logic [63:0] Q180  = 64'd180 << IN_FRAC_BITS;
  localparam logic [63:0] Q270  = 64'd270 << IN_FRAC_BITS;
  // Reduction steps so that MOD_C << QB exceeds any 32-bit length.
  localparam int          QB    = 33 - $clog2(MOD_C);
  localparam logic [58:0] ZRND  = 59'd1 << (IN_FRAC_BITS + 1);
  localparam int          NIT   = TRIG_ITERATIONS;

  // Angle reduction modulo one turn.
  logic [31:0]       md_rem_r  [QB+1];
  logic              md_v_r    [QB+1];
  logic [SIDE_W-1:0] md_side_r [QB+1];

  // Quadrant fold, degree-to-radian product.
  logic [31:0]       fd_a_r;
  logic [1:0]        fd_sg_r;
  logic              fd_v_r;
  logic [SIDE_W-1:0] fd_side_r;
  logic [58:0]       mp_p_r;
  logic [1:0]        mp_sg_r;
  logic              mp_v_r;
  logic [SIDE_W-1:0] mp_side_r;

  // CORDIC iterations; sign bits are {sine negative, cosine negative}.
  cw_t               cr_x_r    [NIT+1];
  cw_t               cr_y_r    [NIT+1];
  cw_t               cr_z_r    [NIT+1];
  logic [1:0]        cr_sg_r   [NIT+1];
  logic              cr_v_r    [NIT+1];
  logic [SIDE_W-1:0] cr_side_r [NIT+1];

  logic              o_v_r;
  cw_t               o_s_r;
  cw_t               o_c_r;
  cw_t               o_t_r;
  logic [SIDE_W-1:0] o_side_r;

  logic [63:0]       d64;
  logic [63:0]       a_nxt;
  logic [1:0]        sg_nxt;
  logic [58:0]       zsum;
  logic [58:0]       zval;
  cw_t               xc;
  cw_t               yc;
  cw_t               c_nxt;
  cw_t               s_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_v_r[0] <= 1'b0;
    end else if (en) begin
      md_v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_rem_r[0]  <= in_len;
      md_side_r[0] <= in_side;
    end
  end

  // Subtract a shifted copy of one turn where it fits, largest first.
  for (genvar k = 0; k < QB; k++) begin : g_mod
    localparam logic [63:0] SUB = MOD_C << (QB - 1 - k);
    logic ge;

    assign ge = {32'd0, md_rem_r[k]} >= SUB;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        md_v_r[k+1] <= 1'b0;
      end else if (en) begin
        md_v_r[k+1] <= md_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        md_rem_r[k+1]  <= ge ? (md_rem_r[k] - SUB[31:0]) : md_rem_r[k];
        md_side_r[k+1] <= md_side_r[k];
      end
    end
  end

  // Fold into the first quadrant.
  always_comb begin
    d64 = {32'd0, md_rem_r[QB]};
    if (d64 <= Q90) begin
      a_nxt  = d64;
      sg_nxt = 2'b00;
    end else if (d64 <= Q180) begin
      a_nxt  = Q180 - d64;
      sg_nxt = 2'b01;
    end else if (d64 <= Q270) begin
      a_nxt  = d64 - Q180;
      sg_nxt = 2'b11;
    end else begin
      a_nxt  = MOD_C - d64;
      sg_nxt = 2'b10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_v_r <= 1'b0;
      mp_v_r <= 1'b0;
    end else if (en) begin
      fd_v_r <= md_v_r[QB];
      mp_v_r <= fd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fd_a_r    <= a_nxt[31:0];
      fd_sg_r   <= sg_nxt;
      fd_side_r <= md_side_r[QB];
      mp_p_r    <= 59'(fd_a_r) * 59'(DEG2RAD_Q32);
      mp_sg_r   <= fd_sg_r;
      mp_side_r <= fd_side_r;
    end
  end

  // Round the radian angle to Q2.30 and seed the rotation.
  always_comb begin
    zsum = mp_p_r + ZRND;
    zval = zsum >> (IN_FRAC_BITS + 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_v_r[0] <= 1'b0;
    end else if (en) begin
      cr_v_r[0] <= mp_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_x_r[0]    <= KINV_WF;
      cr_y_r[0]    <= '0;
      cr_z_r[0]    <= {2'b00, zval[31:0]};
      cr_sg_r[0]   <= mp_sg_r;
      cr_side_r[0] <= mp_side_r;
    end
  end

  // One rotation-mode iteration per stage.
  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    cw_t dx;
    cw_t dy;
    cw_t at;

    assign dx = cr_y_r[i] >>> i;
    assign dy = cr_x_r[i] >>> i;
    assign at = {2'b00, atan_q30(5'(i))};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cr_v_r[i+1] <= 1'b0;
      end else if (en) begin
        cr_v_r[i+1] <= cr_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cr_z_r[i][33]) begin
          cr_x_r[i+1] <= cr_x_r[i] - dx;
          cr_y_r[i+1] <= cr_y_r[i] + dy;
          cr_z_r[i+1] <= cr_z_r[i] - at;
        end else begin
          cr_x_r[i+1] <= cr_x_r[i] + dx;
          cr_y_r[i+1] <= cr_y_r[i] - dy;
          cr_z_r[i+1] <= cr_z_r[i] + at;
        end
        cr_sg_r[i+1]   <= cr_sg_r[i];
        cr_side_r[i+1] <= cr_side_r[i];
      end
    end
  end

  // Clamp to [0, 1], apply quadrant signs, negate the sine, form 1 - c.
  always_comb begin
    if (cr_x_r[NIT][33]) begin
      xc = '0;
    end else if (cr_x_r[NIT] > ONE_WF) begin
      xc = ONE_WF;
    end else begin
      xc = cr_x_r[NIT];
    end
    if (cr_y_r[NIT][33]) begin
      yc = '0;
    end else if (cr_y_r[NIT] > ONE_WF) begin
      yc = ONE_WF;
    end else begin
      yc = cr_y_r[NIT];
    end
    c_nxt = cr_sg_r[NIT][0] ? -xc : xc;
    s_nxt = cr_sg_r[NIT][1] ? yc : -yc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= cr_v_r[NIT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_s_r    <= s_nxt;
      o_c_r    <= c_nxt;
      o_t_r    <= ONE_WF - c_nxt;
      o_side_r <= cr_side_r[NIT];
    end
  end

  assign out_v    = o_v_r;
  assign out_s    = o_s_r;
  assign out_c    = o_c_r;
  assign out_t    = o_t_r;
  assign out_side = o_side_r;

endmodule

`default_nettype wire

// ----- design/aar_matrix.sv -----
`timescale 1ns / 1ps
`default_nettype none

module aar_matrix
  import aar_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_v,
  input  cw_t   in_s,
  input  cw_t   in_c,
  input  cw_t   in_t,
  input  vec3_t in_n,
  input  logic  in_zero,
  output logic  out_v,
  output res_t  out_res
);

  localparam int                 SH  = WF - OUT_FRAC_BITS;
  localparam logic signed [35:0] RND = 36'((64'd1 << SH) >> 1);
  localparam logic signed [35:0] LIM = 36'(64'd1 << OUT_FRAC_BITS);

  // Q2.30 product with round-half-up.
  function automatic cw_t mulq(input cw_t a, input cw_t b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< (WF - 1));
    return p[WF+33:WF];
  endfunction

  function automatic logic signed [34:0] sx(input cw_t v);
    return {v[33], v};
  endfunction

  cw_t               n [3];

  // Stage 1: axis outer products and sine-scaled axis.
  cw_t               p_r [6];
  cw_t               q1_r [3];
  cw_t               c1_r;
  cw_t               t1_r;
  logic              z1_r;
  logic              v1_r;

  // Stage 2: outer products times (1 - c).
  cw_t               u_r [6];
  cw_t               q2_r [3];
  cw_t               c2_r;
  logic              z2_r;
  logic              v2_r;

  // Stage 3: Rodrigues sums.
  logic signed [34:0] e_r [9];
  logic               z3_r;
  logic               v3_r;

  // Stage 4: rounding, saturation and the identity case.
  res_t               o_r;
  logic               v4_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n[k] = {{2{in_n[k][31]}}, in_n[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= mulq(n[0], n[0]);
      p_r[1]  <= mulq(n[0], n[1]);
      p_r[2]  <= mulq(n[0], n[2]);
      p_r[3]  <= mulq(n[1], n[1]);
      p_r[4]  <= mulq(n[1], n[2]);
      p_r[5]  <= mulq(n[2], n[2]);
      q1_r[0] <= mulq(in_s, n[0]);
      q1_r[1] <= mulq(in_s, n[1]);
      q1_r[2] <= mulq(in_s, n[2]);
      c1_r    <= in_c;
      t1_r    <= in_t;
      z1_r    <= in_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        u_r[k] <= mulq(p_r[k], t1_r);
      end
      q2_r <= q1_r;
      c2_r <= c1_r;
      z2_r <= z1_r;
    end
  end

  // Entry order: xx, xy, xz, yy, yz, zz in u_r; s*x, s*y, s*z in q2_r.
  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0] <= sx(u_r[0]) + sx(c2_r);
      e_r[1] <= sx(u_r[1]) + sx(q2_r[2]);
      e_r[2] <= sx(u_r[2]) - sx(q2_r[1]);
      e_r[3] <= sx(u_r[1]) - sx(q2_r[2]);
      e_r[4] <= sx(u_r[3]) + sx(c2_r);
      e_r[5] <= sx(u_r[4]) + sx(q2_r[0]);
      e_r[6] <= sx(u_r[2]) + sx(q2_r[1]);
      e_r[7] <= sx(u_r[4]) - sx(q2_r[0]);
      e_r[8] <= sx(u_r[5]) + sx(c2_r);
      z3_r   <= z2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        logic signed [35:0] r;
        logic signed [35:0] sh;
        logic signed [35:0] sat;
        r  = {e_r[k][34], e_r[k]} + RND;
        sh = r >>> SH;
        if (sh > LIM) begin
          sat = LIM;
        end else if (sh < -LIM) begin
          sat = -LIM;
        end else begin
          sat = sh;
        end
        if (z3_r) begin
          o_r.m[k] <= (k % 4 == 0) ? LIM[31:0] : 32'd0;
        end else begin
          o_r.m[k] <= sat[31:0];
        end
      end
      o_r.zero <= z3_r;
    end
  end

  assign out_v   = v4_r;
  assign out_res = o_r;

endmodule

`default_nettype wire
